FILE: design/aes_pkg.sv
// Shared types, tables and byte-level round functions for the AES-128 cipher.
package aes_pkg;

	localparam int unsigned ROUNDS = 10;
	localparam int unsigned BLOCK_W = 128;
	localparam logic CMD_ENCRYPT = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

	typedef logic [BLOCK_W-1:0] block_t;

	typedef struct packed {
		logic valid;
		logic dec;
	} ctl_t;

	localparam logic [7:0] RCON [ROUNDS] = '{
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
	};

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
	};

	localparam logic [7:0] REV_SBOX [256] = '{
		8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
		8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
		8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
		8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
		8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
		8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
		8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
		8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
		8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
		8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
		8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
		8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
		8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
		8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
		8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
	};

	// Byte i of a block sits in bits 127-8i down; byte 4r+c is row r, column c.
	function automatic logic [7:0] get_byte(input block_t s, input int unsigned i);
		return s[BLOCK_W-1-8*i -: 8];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
	endfunction

	function automatic block_t sub_bytes(input block_t s, input logic inv);
		block_t o;
		for (int i = 0; i < 16; i++) begin
			o[BLOCK_W-1-8*i -: 8] = inv ? REV_SBOX[get_byte(s, i)] : SBOX[get_byte(s, i)];
		end
		return o;
	endfunction

	// Row r rotates left by r, or right by r for the inverse.
	function automatic block_t shift_rows(input block_t s, input logic inv);
		block_t o;
		int unsigned src;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				src = inv ? 4*r + ((c + 3*r) % 4) : 4*r + ((c + r) % 4);
				o[BLOCK_W-1-8*(4*r+c) -: 8] = get_byte(s, src);
			end
		end
		return o;
	endfunction

	function automatic block_t mix_columns(input block_t s);
		block_t o;
		logic [7:0] a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				a0 = get_byte(s, 4*r + c);
				a1 = get_byte(s, 4*((r+1)%4) + c);
				a2 = get_byte(s, 4*((r+2)%4) + c);
				a3 = get_byte(s, 4*((r+3)%4) + c);
				o[BLOCK_W-1-8*(4*r+c) -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
			end
		end
		return o;
	endfunction

	function automatic block_t inv_mix_columns(input block_t s);
		block_t o;
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) begin
				a[k] = get_byte(s, 4*k + c);
				x2[k] = xtime(a[k]);
				x4[k] = xtime(x2[k]);
				x8[k] = xtime(x4[k]);
			end
			for (int r = 0; r < 4; r++) begin
				// 14, 11, 13, 9 along the row, rotated by r
				o[BLOCK_W-1-8*(4*r+c) -: 8] =
					(x8[r] ^ x4[r] ^ x2[r]) ^
					(x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4]) ^
					(x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4]) ^
					(x8[(r+3)%4] ^ a[(r+3)%4]);
			end
		end
		return o;
	endfunction

endpackage

FILE: design/aes_key_cell.sv
// One step of the key schedule: derives and holds the next round key.
module aes_key_cell import aes_pkg::*; #(
	parameter int unsigned STEP = 1
) (
	input  logic   clk,
	input  block_t prev_key,
	output block_t next_key
);

	block_t next_key_q;
	block_t nk;
	logic [7:0] b;

	always_comb begin
		nk = '0;
		for (int r = 0; r < 4; r++) begin
			b = SBOX[get_byte(prev_key, 4*((r+1)%4) + 3)] ^ get_byte(prev_key, 4*r);
			if (r == 0) begin
				b = b ^ RCON[STEP-1];
			end
			nk[BLOCK_W-1-8*(4*r) -: 8] = b;
			for (int c = 1; c < 4; c++) begin
				b = b ^ get_byte(prev_key, 4*r + c);
				nk[BLOCK_W-1-8*(4*r+c) -: 8] = b;
			end
		end
	end

	always_ff @(posedge clk) begin
		next_key_q <= nk;
	end

	assign next_key = next_key_q;

endmodule

FILE: design/aes_round_cell.sv
// One cipher round, forward or inverse per word, with its output register.
module aes_round_cell import aes_pkg::*; #(
	parameter bit LAST = 1'b0
) (
	input  logic   clk,
	input  logic   arst_n,
	input  ctl_t   ctl_in,
	input  block_t state_in,
	input  block_t enc_key,
	input  block_t dec_key,
	output ctl_t   ctl_out,
	output block_t state_out
);

	ctl_t   ctl_q;
	block_t state_q;
	block_t enc_v;
	block_t dec_v;

	always_comb begin
		enc_v = shift_rows(sub_bytes(state_in, CMD_ENCRYPT), CMD_ENCRYPT);
		if (!LAST) begin
			enc_v = mix_columns(enc_v);
		end
		enc_v = enc_v ^ enc_key;
		dec_v = sub_bytes(shift_rows(state_in, CMD_DECRYPT), CMD_DECRYPT) ^ dec_key;
		if (!LAST) begin
			dec_v = inv_mix_columns(dec_v);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		state_q <= (ctl_in.dec == CMD_DECRYPT) ? dec_v : enc_v;
	end

	assign ctl_out = ctl_q;
	assign state_out = state_q;

endmodule

FILE: design/aes128_block_cipher.sv
// AES-128 encrypt/decrypt: a new block can start every cycle.
// A word is taken at every edge with start high (busy is always low) and its result is shown
// on result_high/result_low for one cycle with done high, in order; the receiver cannot
// stall it. The path is a 10-stage input delay that lets the registered key-schedule cells
// settle after a key write, one key-add stage and ten round cells. Write the key only with
// nothing in flight.
module aes128_block_cipher import aes_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [63:0] data_high,
	input  logic [63:0] data_low,
	output logic        done,
	output logic [63:0] result_high,
	output logic [63:0] result_low,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam logic [1:0] REG_KEY_HIGH = 2'd0;
	localparam logic [1:0] REG_KEY_LOW  = 2'd1;
	localparam int unsigned DELAY = ROUNDS;

	logic [63:0] key_high_q;
	logic [63:0] key_low_q;
	block_t      rk [ROUNDS+1];

	ctl_t   dly_ctl_q  [DELAY];
	block_t dly_data_q [DELAY];
	ctl_t   ctl_s0;
	block_t state_s0;
	ctl_t   ctl_c   [ROUNDS+1];
	block_t state_c [ROUNDS+1];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_KEY_LOW:  key_low_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rk[0] = {key_high_q, key_low_q};

	for (genvar n = 1; n <= ROUNDS; n++) begin : g_key
		aes_key_cell #(.STEP(n)) u_key (
			.clk(clk),
			.prev_key(rk[n-1]),
			.next_key(rk[n])
		);
	end

	// Hold each word until the key chain has settled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DELAY; i++) begin
				dly_ctl_q[i] <= '0;
			end
			ctl_s0 <= '0;
		end else begin
			dly_ctl_q[0] <= '{valid: start & ~busy, dec: command};
			for (int i = 1; i < DELAY; i++) begin
				dly_ctl_q[i] <= dly_ctl_q[i-1];
			end
			ctl_s0 <= dly_ctl_q[DELAY-1];
		end
	end

	always_ff @(posedge clk) begin
		dly_data_q[0] <= {data_high, data_low};
		for (int i = 1; i < DELAY; i++) begin
			dly_data_q[i] <= dly_data_q[i-1];
		end
		state_s0 <= dly_data_q[DELAY-1] ^
			((dly_ctl_q[DELAY-1].dec == CMD_DECRYPT) ? rk[ROUNDS] : rk[0]);
	end

	assign ctl_c[0] = ctl_s0;
	assign state_c[0] = state_s0;

	for (genvar k = 1; k <= ROUNDS; k++) begin : g_round
		aes_round_cell #(.LAST(k == ROUNDS)) u_round (
			.clk(clk),
			.arst_n(arst_n),
			.ctl_in(ctl_c[k-1]),
			.state_in(state_c[k-1]),
			.enc_key(rk[k]),
			.dec_key(rk[ROUNDS-k]),
			.ctl_out(ctl_c[k]),
			.state_out(state_c[k])
		);
	end

	assign done = ctl_c[ROUNDS].valid;
	assign result_high = state_c[ROUNDS][BLOCK_W-1:64];
	assign result_low = state_c[ROUNDS][63:0];

	a_entry_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s0.valid |-> ##10 done)
		else $error("word entering the rounds did not finish");

	a_done_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(ctl_s0.valid, 10))
		else $error("result without a word in the rounds");

	a_start_to_entry: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##11 ctl_s0.valid)
		else $error("accepted word lost in the delay line");

	a_mode_kept: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s0.valid |-> ##10 (ctl_c[ROUNDS].dec == $past(ctl_s0.dec, 10)))
		else $error("direction changed in flight");

endmodule
